// ===== design/i2da_pkg.sv =====
package i2da_pkg;

    // character codes and conversion geometry
    localparam logic [7:0] CHAR_ZERO     = 8'd48;
    localparam logic [7:0] CHAR_MINUS    = 8'd45;
    localparam int         RADIX         = 10;
    localparam int         NUM_DIGITS    = 10;
    localparam int         BCD_W         = 4 * NUM_DIGITS;
    localparam int         DIGIT_IDX_W   = 4;
    localparam int         BITS_PER_STEP = 2;
    localparam int         NUM_STEPS     = 32 / BITS_PER_STEP;
    localparam int         STEP_CNT_W    = 4;

    // commands from controller to datapath
    typedef struct packed {
        logic                   load;
        logic                   step;
        logic                   emit_sign;
        logic                   emit_digit;
        logic                   last;
        logic [DIGIT_IDX_W-1:0] digit_idx;
    } i2da_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic                   negative;
        logic [DIGIT_IDX_W-1:0] msd_idx;
    } i2da_status_t;

endpackage

// ===== design/int32_to_decimal_ascii_top.sv =====
// Converts a signed 32-bit number to its decimal ASCII text, most significant
// character first: '-' for a negative value, then the digits without leading
// zeros ('0' for zero). A number is taken when start is high while busy is
// low. The magnitude goes through a double-dabble converter that handles two
// bits a cycle, then the sign state settles the digit count and sends the
// sign when there is one, and each digit leaves on its own cycle, and the next
// number can only be taken once the last digit has left. Every character
// appears for exactly one cycle with char_strobe high, last_char marks the
// final one; the receiver cannot stall and must take each transfer as it
// comes.
module int32_to_decimal_ascii_top
    import i2da_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] number,
    output logic [7:0]         ascii_char,
    output logic               last_char,
    output logic               char_strobe
);

    i2da_cmd_t    cmd;
    i2da_status_t status;

    // sequencer
    i2da_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // converter and character register
    i2da_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .number      (number),
        .status      (status),
        .ascii_char  (ascii_char),
        .last_char   (last_char),
        .char_strobe (char_strobe)
    );

endmodule

// ===== design/i2da_datapath.sv =====
module i2da_datapath
    import i2da_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  i2da_cmd_t           cmd,
    input  logic signed [31:0]  number,
    output i2da_status_t        status,
    output logic [7:0]          ascii_char,
    output logic                last_char,
    output logic                char_strobe
);

    logic [31:0]      bin_reg;
    logic [31:0]      bin_next;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    logic             neg_reg;
    logic             neg_next;
    logic [7:0]       char_reg;
    logic [7:0]       char_next;
    logic             last_reg;
    logic             last_next;
    logic             strobe_reg;
    logic             strobe_next;

    logic [BCD_W-1:0] bcd_adj_first;
    logic [BCD_W-1:0] bcd_half;
    logic [BCD_W-1:0] bcd_adj_second;
    logic [3:0]       sel_digit;
    logic [DIGIT_IDX_W-1:0] msd_idx;

    // add three to every bcd digit of five or more before a shift
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        r = v;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (v[4*i +: 4] >= 4'd5)
            begin
                r[4*i +: 4] = v[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    // highest nonzero digit, zero when the value is zero
    always_comb
    begin
        msd_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
            begin
                msd_idx = DIGIT_IDX_W'(i);
            end
        end
    end

    // digit picked by the controller's index
    always_comb
    begin
        sel_digit = 4'd0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (cmd.digit_idx == DIGIT_IDX_W'(i))
            begin
                sel_digit = bcd_reg[4*i +: 4];
            end
        end
    end

    // magnitude load and two double-dabble steps per cycle
    always_comb
    begin
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        bcd_adj_first  = bcd_adjust(bcd_reg);
        bcd_half       = {bcd_adj_first[BCD_W-2:0], bin_reg[31]};
        bcd_adj_second = bcd_adjust(bcd_half);
        if (cmd.load)
        begin
            neg_next = number[31];
            bin_next = number[31] ? (32'd0 - 32'(number)) : 32'(number);
            bcd_next = '0;
        end
        else if (cmd.step)
        begin
            bcd_next = {bcd_adj_second[BCD_W-2:0], bin_reg[30]};
            bin_next = {bin_reg[29:0], 2'b00};
        end
    end

    // character output register
    always_comb
    begin
        strobe_next = cmd.emit_sign | cmd.emit_digit;
        last_next   = last_reg;
        char_next   = char_reg;
        if (cmd.emit_sign)
        begin
            char_next = CHAR_MINUS;
            last_next = 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_next = CHAR_ZERO + {4'd0, sel_digit};
            last_next = cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.negative = neg_reg;
    assign status.msd_idx  = msd_idx;
    assign ascii_char      = char_reg;
    assign last_char       = last_reg;
    assign char_strobe     = strobe_reg;

endmodule

// ===== design/i2da_ctrl.sv =====
module i2da_ctrl
    import i2da_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  i2da_status_t status,
    output i2da_cmd_t    cmd,
    output logic         busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_DIGITS
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [STEP_CNT_W-1:0]  step_reg;
    logic [STEP_CNT_W-1:0]  step_next;
    logic [DIGIT_IDX_W-1:0] idx_reg;
    logic [DIGIT_IDX_W-1:0] idx_next;

    // sequencing: load, convert, optional sign, digits from the top
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        cmd.emit_sign  = 1'b0;
        cmd.emit_digit = 1'b0;
        cmd.last       = (idx_reg == '0);
        cmd.digit_idx  = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_CNT_W'(NUM_STEPS - 1))
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                // digit count is known once conversion has settled
                cmd.emit_sign = status.negative;
                idx_next      = status.msd_idx;
                state_next    = S_DIGITS;
            end
            S_DIGITS:
            begin
                cmd.emit_digit = 1'b1;
                idx_next       = idx_reg - 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== test/tb_int32_to_decimal_ascii_top.sv =====
`timescale 1ns / 1ps

module tb_int32_to_decimal_ascii_top;
    import i2da_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 4;
    localparam int DRAIN_CYCLES  = 40;
    localparam int MAX_GAP       = 35;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_DIRECTED  = 22;

    // one expected character of a number's text
    typedef struct {
        logic [7:0] code;
        logic       last;
    } digit_char_t;

    // directed row: text_len of zero means the predictor supplies the text
    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  text_len;
        logic [87:0] text;
    } text_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] number;
    logic [7:0]  ascii_char;
    logic        last_char;
    logic        char_strobe;

    digit_char_t pending_chars [$];
    digit_char_t head_char;
    int          error_count;
    int          cycle_count;

    text_row_t directed_rows [0:NUM_DIRECTED-1] = '{
        '{32'd0,          4'd1,  "0"},
        '{32'd1,          4'd1,  "1"},
        '{32'hFFFFFFFF,   4'd2,  "-1"},
        '{32'd9,          4'd1,  "9"},
        '{32'd10,         4'd2,  "10"},
        '{32'hFFFFFFF6,   4'd3,  "-10"},
        '{32'h7FFFFFFF,   4'd10, "2147483647"},
        '{32'h80000000,   4'd11, "-2147483648"},
        '{32'h80000001,   4'd11, "-2147483647"},
        '{32'd0,          4'd1,  "0"},
        '{32'd99,         4'd0,  88'd0},
        '{32'd100,        4'd0,  88'd0},
        '{32'hFFFFFF9D,   4'd0,  88'd0},
        '{32'd999999999,  4'd0,  88'd0},
        '{32'd1000000000, 4'd0,  88'd0},
        '{32'hC4653600,   4'd0,  88'd0},
        '{32'd1234567890, 4'd0,  88'd0},
        '{32'hB669FD2E,   4'd0,  88'd0},
        '{32'h55555555,   4'd0,  88'd0},
        '{32'hAAAAAAAA,   4'd0,  88'd0},
        '{32'd65536,      4'd0,  88'd0},
        '{32'hFFFF0000,   4'd0,  88'd0}
    };

    int32_to_decimal_ascii_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .number      (number),
        .ascii_char  (ascii_char),
        .last_char   (last_char),
        .char_strobe (char_strobe)
    );

    // free-running clock
    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // decimal text of a 32-bit two's complement value, queued in send order
    function automatic void predict_decimal_text(input logic [31:0] bits);
        logic [31:0] mag;
        logic [7:0]  digs [NUM_DIGITS];
        int          nd;
        digit_char_t c;
        mag = bits[31] ? (32'd0 - bits) : bits;
        nd  = 0;
        while (nd == 0 || (mag != 32'd0 && nd < NUM_DIGITS))
        begin
            digs[nd] = CHAR_ZERO + 8'(mag % 32'(RADIX));
            mag      = mag / 32'(RADIX);
            nd++;
        end
        if (bits[31])
        begin
            c.code = CHAR_MINUS;
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            c.code = digs[i];
            c.last = (i == 0);
            pending_chars.push_back(c);
        end
    endfunction

    // queue hand-typed text from a directed row
    function automatic void queue_typed_text(input text_row_t row);
        digit_char_t c;
        int          n;
        n = int'(row.text_len);
        for (int k = 0; k < n; k++)
        begin
            c.code = row.text[8 * (n - 1 - k) +: 8];
            c.last = (k == n - 1);
            pending_chars.push_back(c);
        end
    endfunction

    // mix of digit counts, decade boundaries and extremes
    function automatic logic [31:0] random_number();
        logic [31:0] v;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0: v = 32'd0;
                    1: v = 32'h7FFFFFFF;
                    2: v = 32'h80000000;
                    default: v = 32'hFFFFFFFF;
                endcase
            end
            1, 2:
            begin
                v = $urandom;
            end
            3, 4:
            begin
                v = 32'd1;
                repeat ($urandom_range(0, 9)) v = v * 32'd10;
                v = v - 32'($urandom_range(0, 1));
                if ($urandom_range(1) == 1)
                    v = 32'd0 - v;
            end
            default:
            begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(1) == 1)
                    v = 32'd0 - v;
            end
        endcase
        return v;
    endfunction

    // offer one number, optionally after an idle gap; returns at the transfer edge
    task automatic send_number(input logic [31:0] value, input int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP))
            begin
                number <= $urandom;
                @(posedge clk);
            end
        end
        start  <= 1'b1;
        number <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        logic [31:0] v;
        rst_n       = 1'b0;
        start       = 1'b0;
        number      = 32'd0;
        error_count = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            send_number(directed_rows[r].value, 0);
            if (directed_rows[r].text_len != 4'd0)
                queue_typed_text(directed_rows[r]);
            else
                predict_decimal_text(directed_rows[r].value);
        end

        // random phases: back to back, heavy sender idling, light idling
        for (int i = 0; i < 120; i++)
        begin
            v = random_number();
            send_number(v, 0);
            predict_decimal_text(v);
        end
        for (int i = 0; i < 120; i++)
        begin
            v = random_number();
            send_number(v, 48);
            predict_decimal_text(v);
        end
        for (int i = 0; i < 110; i++)
        begin
            v = random_number();
            send_number(v, 6);
            predict_decimal_text(v);
        end
        start <= 1'b0;

        // drain, then let any stray output show up
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_chars.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // character checker: every strobed transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && char_strobe)
        begin
            if (pending_chars.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected char: code %0d last %0d", ascii_char, last_char);
            end
            else
            begin
                head_char = pending_chars.pop_front();
                if (ascii_char !== head_char.code || last_char !== head_char.last)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("char mismatch: expected code %0d last %0d, got code %0d last %0d",
                                 head_char.code, head_char.last, ascii_char, last_char);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
    end

endmodule

// ===== sim.f =====
design/i2da_pkg.sv
design/i2da_datapath.sv
design/i2da_ctrl.sv
design/int32_to_decimal_ascii_top.sv
test/tb_int32_to_decimal_ascii_top.sv
